// ----- rtl/looping_sample_player_top_macros.svh -----
// Assertion helpers for the sample player. Both expect clk and arst_n in scope.
`ifndef LOOPING_SAMPLE_PLAYER_TOP_MACROS_SVH
`define LOOPING_SAMPLE_PLAYER_TOP_MACROS_SVH

// Same-cycle implication
`define LSP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define LSP_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/lsp_pkg.sv -----
package lsp_pkg;

	// Default structure parameters
	localparam int SAMPLE_DEPTH_DEF = 65536;
	localparam int FRAC_BITS_DEF    = 16;

	// Fixed widths
	localparam int POS_W = 34;
	localparam int CFG_W = 20;

	// Item kinds
	localparam logic [1:0] KIND_LOAD    = 2'd0;
	localparam logic [1:0] KIND_RESTART = 2'd1;
	localparam logic [1:0] KIND_TICK    = 2'd2;

	// Loop modes
	localparam logic [1:0] LOOP_NONE = 2'd0;
	localparam logic [1:0] LOOP_FWD  = 2'd1;
	localparam logic [1:0] LOOP_PING = 2'd2;

	// Register indexes
	localparam logic [2:0] REG_SAMPLE_LENGTH = 3'd0;
	localparam logic [2:0] REG_LOOP_MODE     = 3'd1;
	localparam logic [2:0] REG_LOOP_START    = 3'd2;
	localparam logic [2:0] REG_LOOP_END      = 3'd3;
	localparam logic [2:0] REG_STEP_RATE     = 3'd4;
	localparam logic [2:0] REG_STEREO        = 3'd5;
	localparam logic [2:0] REG_GAIN          = 3'd6;

	// Register reset values
	localparam logic [19:0] STEP_RATE_RST = 20'd65536;
	localparam logic [15:0] GAIN_RST      = 16'd32768;

	// Tick sequencer
	typedef enum logic [3:0] {
		S_IDLE,
		S_RD0,
		S_RD1,
		S_MUL_L,
		S_MUL_R,
		S_GAIN_L,
		S_GAIN_R,
		S_SAT,
		S_OUT
	} state_t;

endpackage

// ----- rtl/lsp_mem.sv -----
module lsp_mem import lsp_pkg::*; #(
	parameter int DEPTH = SAMPLE_DEPTH_DEF,
	parameter int AW    = $clog2(SAMPLE_DEPTH_DEF)
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  logic signed [15:0]   wr_left,
	input  logic signed [15:0]   wr_right,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output logic signed [15:0]   rd_left,
	output logic signed [15:0]   rd_right
);

	logic signed [15:0] mem_l [DEPTH];
	logic signed [15:0] mem_r [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_l[wr_addr] <= wr_left;
			mem_r[wr_addr] <= wr_right;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_left  <= mem_l[rd_addr];
			rd_right <= mem_r[rd_addr];
		end
	end

endmodule

// ----- rtl/looping_sample_player_top.sv -----
// Channel   Dir  Handshake             Payload
// in        in   in_valid / in_stall   kind, address, left_word, right_word
// out       out  out_valid / out_stall left_out, right_out, done_res
// cfg       in   cfg_we                cfg_index, cfg_wdata
//
// Loads and restarts stay in the idle state. A tick on a finished voice goes to the
// output step, a tick that hits the end reads once, a playing tick does two reads on
// the single sample memory read port, then four passes through one shared multiplier.
// Reset clears the position and sets the voice finished; sample memory is not cleared.
// in_stall is high while a tick is in work; out_stall holds the result register and
// a new tick result waits in the sequencer until that register frees up.
module looping_sample_player_top import lsp_pkg::*; #(
	parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF,
	parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [CFG_W-1:0]    cfg_wdata,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          kind,
	input  logic [15:0]         address,
	input  logic signed [15:0]  left_word,
	input  logic signed [15:0]  right_word,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [15:0]  left_out,
	output logic signed [15:0]  right_out,
	output logic                done_res
);

	localparam int F   = FRAC_BITS;
	localparam int PW  = POS_W - F;
	localparam int AW  = $clog2(SAMPLE_DEPTH);
	localparam int BW  = ((F > 16) ? F : 16) + 1;
	localparam int PRW = 18 + BW;
	localparam int CW  = ((20 + F) > 37) ? (20 + F) : 37;
	localparam logic signed [PRW-1:0] HALF_F  = PRW'(1) <<< (F - 1);
	localparam logic signed [PRW-1:0] HALF_G  = PRW'(16384);
	localparam logic signed [PRW-1:0] SAT_MAX = PRW'(32767);
	localparam logic signed [PRW-1:0] SAT_MIN = -PRW'(32768);
	localparam logic signed [CW-1:0]  POS_MAX = CW'(35'h3_FFFF_FFFF);

	// Configuration registers
	logic [16:0] slen_q;
	logic [1:0]  mode_q;
	logic [15:0] lstart_q;
	logic [16:0] lend_q;
	logic [19:0] step_q;
	logic        stereo_q;
	logic [15:0] gain_q;

	// Voice state
	logic [POS_W-1:0] pos_q;
	logic             back_q;
	logic             finished_q;

	// Sequencer and datapath
	state_t state_q, state_d;
	logic                   accept;
	logic                   mem_wr_en, mem_rd_en;
	logic [AW-1:0]          mem_rd_addr;
	logic signed [15:0]     rd_left, rd_right;
	logic                   oob0_q, oob1_q;
	logic signed [15:0]     s0l_q, s0r_q, s1r_q;
	logic signed [15:0]     s1l, s1r;
	logic signed [17:0]     lerp_l_q, lerp_r_q;
	logic signed [17:0]     mul_a;
	logic signed [BW-1:0]   mul_b;
	logic signed [PRW-1:0]  mul_p, prod_q;
	logic signed [PRW-1:0]  rnd_sum, rnd_shr, g_sum, g_shr;
	logic signed [17:0]     rnd_val;
	logic signed [15:0]     sat_val;
	logic signed [15:0]     res_l_q, res_r_q;
	logic [PW-1:0]          p_int;
	logic [F-1:0]           frac;
	logic                   end_hit;
	logic signed [CW-1:0]   pos_ext, step_ext, lo_ext, hi_ext, len_ext;
	logic signed [CW-1:0]   pos_step_q, delta_q, bound_q;
	logic signed [CW-1:0]   wrap_pos, clamp_pos;
	logic                   hit;
	logic                   out_free;

	assign accept   = in_valid && !in_stall;
	assign p_int    = pos_q[POS_W-1:F];
	assign frac     = pos_q[F-1:0];
	assign end_hit  = (35'(p_int) + 35'(1)) >= 35'(slen_q);
	assign out_free = !out_valid || !out_stall;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slen_q   <= '0;
			mode_q   <= LOOP_NONE;
			lstart_q <= '0;
			lend_q   <= '0;
			step_q   <= STEP_RATE_RST;
			stereo_q <= 1'b0;
			gain_q   <= GAIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SAMPLE_LENGTH: slen_q   <= cfg_wdata[16:0];
				REG_LOOP_MODE:     mode_q   <= cfg_wdata[1:0];
				REG_LOOP_START:    lstart_q <= cfg_wdata[15:0];
				REG_LOOP_END:      lend_q   <= cfg_wdata[16:0];
				REG_STEP_RATE:     step_q   <= cfg_wdata[19:0];
				REG_STEREO:        stereo_q <= cfg_wdata[0];
				REG_GAIN:          gain_q   <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// Sample memory
	assign mem_wr_en = accept && (kind == KIND_LOAD) && (32'(address) < 32'(SAMPLE_DEPTH));

	lsp_mem #(
		.DEPTH (SAMPLE_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk      (clk),
		.wr_en    (mem_wr_en),
		.wr_addr  (AW'(address)),
		.wr_left  (left_word),
		.wr_right (right_word),
		.rd_en    (mem_rd_en),
		.rd_addr  (mem_rd_addr),
		.rd_left  (rd_left),
		.rd_right (rd_right)
	);

	// Sequencer next state and control
	always_comb begin
		state_d     = state_q;
		in_stall    = 1'b1;
		mem_rd_en   = 1'b0;
		mem_rd_addr = AW'(p_int);
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid && kind == KIND_TICK) begin
					state_d = finished_q ? S_OUT : S_RD0;
				end
			end
			S_RD0: begin
				mem_rd_en = 1'b1;
				state_d   = end_hit ? S_OUT : S_RD1;
			end
			S_RD1: begin
				mem_rd_en   = 1'b1;
				mem_rd_addr = AW'(35'(p_int) + 35'(1));
				state_d     = S_MUL_L;
			end
			S_MUL_L:  state_d = S_MUL_R;
			S_MUL_R:  state_d = S_GAIN_L;
			S_GAIN_L: state_d = S_GAIN_R;
			S_GAIN_R: state_d = S_SAT;
			S_SAT:    state_d = S_OUT;
			S_OUT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Second frame of the pair, zero beyond memory
	assign s1l = oob1_q ? 16'sd0 : rd_left;
	assign s1r = oob1_q ? 16'sd0 : rd_right;

	// Shared multiplier operand select
	always_comb begin
		mul_a = 18'(s1l) - 18'(s0l_q);
		mul_b = $signed({{(BW - F){1'b0}}, frac});
		case (state_q)
			S_MUL_R: mul_a = 18'(s1r_q) - 18'(s0r_q);
			S_GAIN_L: begin
				mul_a = lerp_l_q;
				mul_b = $signed({{(BW - 16){1'b0}}, gain_q});
			end
			S_GAIN_R: begin
				mul_a = lerp_r_q;
				mul_b = $signed({{(BW - 16){1'b0}}, gain_q});
			end
			default: ;
		endcase
	end

	assign mul_p = PRW'(mul_a) * PRW'(mul_b);

	// Interpolation rounding and gain rounding with saturation
	assign rnd_sum = prod_q + HALF_F;
	assign rnd_shr = rnd_sum >>> F;
	assign rnd_val = $signed(rnd_shr[17:0]);
	assign g_sum   = prod_q + HALF_G;
	assign g_shr   = g_sum >>> 15;
	assign sat_val = (g_shr > SAT_MAX) ? 16'sh7FFF :
	                 (g_shr < SAT_MIN) ? -16'sh8000 : $signed(g_shr[15:0]);

	// Position arithmetic in a signed frame wide enough for the loop bounds
	assign pos_ext  = $signed({{(CW - POS_W){1'b0}}, pos_q});
	assign step_ext = $signed({{(CW - 20){1'b0}}, step_q});
	assign lo_ext   = $signed({{(CW - 16 - F){1'b0}}, lstart_q, {F{1'b0}}});
	assign hi_ext   = $signed({{(CW - 17 - F){1'b0}}, lend_q, {F{1'b0}}});
	assign len_ext  = $signed({{(CW - 17 - F){1'b0}}, slen_q, {F{1'b0}}});

	// Boundary test and wrap/reflect
	always_comb begin
		hit      = (mode_q == LOOP_PING && back_q) ? (pos_step_q <= bound_q)
		                                           : (pos_step_q >= bound_q);
		wrap_pos = pos_step_q;
		if (hit) begin
			case (mode_q)
				LOOP_FWD:  wrap_pos = pos_step_q + delta_q;
				LOOP_PING: wrap_pos = delta_q - pos_step_q;
				default:   wrap_pos = pos_step_q;
			endcase
		end
		if (wrap_pos < 0) begin
			clamp_pos = '0;
		end else if (wrap_pos > POS_MAX) begin
			clamp_pos = POS_MAX;
		end else begin
			clamp_pos = wrap_pos;
		end
	end

	// Voice state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			back_q     <= 1'b0;
			finished_q <= 1'b1;
		end else begin
			if (accept && kind == KIND_RESTART) begin
				pos_q      <= '0;
				back_q     <= 1'b0;
				finished_q <= 1'b0;
			end
			if (state_q == S_RD0 && end_hit) begin
				finished_q <= 1'b1;
			end
			if (state_q == S_MUL_R) begin
				pos_q <= clamp_pos[POS_W-1:0];
				if (hit) begin
					case (mode_q)
						LOOP_FWD:  ;
						LOOP_PING: back_q <= !back_q;
						default:   finished_q <= 1'b1;
					endcase
				end
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				res_l_q <= '0;
				res_r_q <= '0;
			end
			S_RD0: begin
				oob0_q <= 35'(p_int) >= 35'(SAMPLE_DEPTH);
				oob1_q <= (35'(p_int) + 35'(1)) >= 35'(SAMPLE_DEPTH);
			end
			S_RD1: begin
				s0l_q <= oob0_q ? 16'sd0 : rd_left;
				s0r_q <= oob0_q ? 16'sd0 : rd_right;
			end
			S_MUL_L: begin
				prod_q     <= mul_p;
				s1r_q      <= s1r;
				pos_step_q <= back_q ? pos_ext - step_ext : pos_ext + step_ext;
				case (mode_q)
					LOOP_FWD: begin
						bound_q <= hi_ext;
						delta_q <= lo_ext - hi_ext;
					end
					LOOP_PING: begin
						bound_q <= back_q ? lo_ext : hi_ext;
						delta_q <= back_q ? (lo_ext <<< 1) : (hi_ext <<< 1);
					end
					default: begin
						bound_q <= len_ext;
						delta_q <= '0;
					end
				endcase
			end
			S_MUL_R: begin
				prod_q   <= mul_p;
				lerp_l_q <= 18'(s0l_q) + rnd_val;
			end
			S_GAIN_L: begin
				prod_q   <= mul_p;
				lerp_r_q <= stereo_q ? 18'(s0r_q) + rnd_val : lerp_l_q;
			end
			S_GAIN_R: begin
				prod_q  <= mul_p;
				res_l_q <= sat_val;
			end
			S_SAT: res_r_q <= sat_val;
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			left_out  <= res_l_q;
			right_out <= res_r_q;
			done_res  <= finished_q;
		end
	end

	// Checks
	`include "looping_sample_player_top_macros.svh"

	`LSP_ASSERT_NXT(a_restart_rewinds, accept && kind == KIND_RESTART, !finished_q && pos_q == '0, "restart did not rewind voice")
	`LSP_ASSERT_NXT(a_tick_busy, accept && kind == KIND_TICK, state_q != S_IDLE, "tick item did not start sequencer")
	`LSP_ASSERT_IMP(a_result_from_out, $rose(out_valid), $past(state_q == S_OUT), "result appeared outside output step")

endmodule

// ----- dv/tb_top.sv -----
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lsp_pkg::*;

	localparam int         FRAC          = FRAC_BITS_DEF;
	localparam longint     POS_MAX       = (longint'(1) << POS_W) - 1;
	localparam logic [1:0] KIND_SPARE    = 2'd3;
	localparam logic [1:0] LOOP_SPARE    = 2'd3;
	localparam logic [2:0] REG_SPARE     = 3'd7;
	localparam int         SETTLE_CYCLES = 12;
	localparam int         RANDOM_ITEMS  = 950;

	typedef struct packed {
		logic signed [15:0] left;
		logic signed [15:0] right;
		logic               done;
	} audio_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [CFG_W-1:0]   cfg_wdata;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         kind;
	logic [15:0]        address;
	logic signed [15:0] left_word;
	logic signed [15:0] right_word;
	logic               out_valid;
	logic               out_stall;
	logic signed [15:0] left_out;
	logic signed [15:0] right_out;
	logic               done_res;

	// voice model: sample store, playback state, register copies
	logic signed [15:0] left_frames[int];
	logic signed [15:0] right_frames[int];
	longint             voice_pos     = 0;
	bit                 voice_reverse = 1'b0;
	bit                 voice_done    = 1'b1;
	logic [16:0]        sample_len    = '0;
	logic [1:0]         play_mode     = LOOP_NONE;
	logic [15:0]        loop_lo       = '0;
	logic [16:0]        loop_hi       = '0;
	logic [19:0]        pos_step      = STEP_RATE_RST;
	logic               stereo_on     = 1'b0;
	logic [15:0]        level         = GAIN_RST;

	audio_t pending_audio[$];
	int     idle_pct     = 0;
	int     stall_pct    = 0;
	int     items_sent   = 0;
	int     ticks_sent   = 0;
	int     results_seen = 0;
	int     error_count  = 0;

	looping_sample_player_top dut (.*);

	always #6 clk = ~clk;

	// receiver stall
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// compare each accepted result with the oldest prediction
	always @(posedge clk) begin : check_results
		audio_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_audio.size() == 0) begin
				$error("result with nothing pending: left %0d right %0d done %0b",
					left_out, right_out, done_res);
				error_count++;
			end else begin
				want = pending_audio.pop_front();
				results_seen++;
				if (left_out !== want.left) begin
					$error("left_out: expected %0d, got %0d", want.left, left_out);
					error_count++;
				end
				if (right_out !== want.right) begin
					$error("right_out: expected %0d, got %0d", want.right, right_out);
					error_count++;
				end
				if (done_res !== want.done) begin
					$error("done_res: expected %0b, got %0b", want.done, done_res);
					error_count++;
				end
			end
		end
	end

	// random 16-bit payload word
	function automatic logic [15:0] rand_word();
		return 16'($urandom);
	endfunction

	function automatic longint fetch_frame(bit right_ch, longint idx);
		if (idx < 0 || idx >= SAMPLE_DEPTH_DEF)
			return 0;
		if (right_ch) begin
			if (right_frames.exists(int'(idx)))
				return longint'(right_frames[int'(idx)]);
		end else begin
			if (left_frames.exists(int'(idx)))
				return longint'(left_frames[int'(idx)]);
		end
		return 0;
	endfunction

	// linear interpolation, rounded, floor on the fraction product
	function automatic longint lerp_frame(bit right_ch, longint p, longint frac);
		longint s0, s1;
		s0 = fetch_frame(right_ch, p);
		s1 = fetch_frame(right_ch, p + 1);
		return s0 + (((s1 - s0) * frac + (longint'(1) << (FRAC - 1))) >>> FRAC);
	endfunction

	// Q1.15 gain with rounding, saturated to 16 bits
	function automatic logic signed [15:0] apply_level(longint v);
		longint q;
		q = (v * longint'(level) + 16384) >>> 15;
		if (q > 32767)
			q = 32767;
		if (q < -32768)
			q = -32768;
		return q[15:0];
	endfunction

	// one tick: output, then step and loop handling
	function automatic void render_tick();
		audio_t res;
		longint p, frac, l, r, lo, hi;
		res = '{left: 16'sd0, right: 16'sd0, done: 1'b1};
		if (!voice_done) begin
			p = voice_pos >>> FRAC;
			if (p >= longint'(sample_len) - 1) begin
				voice_done = 1'b1;
			end else begin
				frac = voice_pos & ((longint'(1) << FRAC) - 1);
				l = lerp_frame(1'b0, p, frac);
				r = stereo_on ? lerp_frame(1'b1, p, frac) : l;
				res.left  = apply_level(l);
				res.right = apply_level(r);
				voice_pos += voice_reverse ? -longint'(pos_step) : longint'(pos_step);
				lo = longint'(loop_lo) << FRAC;
				hi = longint'(loop_hi) << FRAC;
				case (play_mode)
					LOOP_FWD: begin
						if (voice_pos >= hi)
							voice_pos = lo + (voice_pos - hi);
					end
					LOOP_PING: begin
						if (!voice_reverse && voice_pos >= hi) begin
							voice_pos = 2 * hi - voice_pos;
							voice_reverse = 1'b1;
						end else if (voice_reverse && voice_pos <= lo) begin
							voice_pos = 2 * lo - voice_pos;
							voice_reverse = 1'b0;
						end
					end
					default: begin
						if (voice_pos >= (longint'(sample_len) << FRAC))
							voice_done = 1'b1;
					end
				endcase
				if (voice_pos < 0)
					voice_pos = 0;
				if (voice_pos > POS_MAX)
					voice_pos = POS_MAX;
				res.done = voice_done;
			end
		end
		pending_audio.push_back(res);
	endfunction

	function automatic void apply_item(logic [1:0] k, logic [15:0] a,
			logic [15:0] lw, logic [15:0] rw);
		case (k)
			KIND_LOAD: begin
				left_frames[int'(a)]  = lw;
				right_frames[int'(a)] = rw;
			end
			KIND_RESTART: begin
				voice_pos     = 0;
				voice_reverse = 1'b0;
				voice_done    = 1'b0;
			end
			KIND_TICK: render_tick();
			default: ;
		endcase
	endfunction

	// one item over the input channel, with optional leading idle cycles
	task automatic send_item(input logic [1:0] k, input logic [15:0] a,
			input logic [15:0] lw, input logic [15:0] rw);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		in_valid   <= 1'b1;
		kind       <= k;
		address    <= a;
		left_word  <= lw;
		right_word <= rw;
		do @(posedge clk); while (in_stall);
		apply_item(k, a, lw, rw);
		if (k != KIND_SPARE)
			items_sent++;
	endtask

	// the next tick reads frames p and p+1: load any that were never written
	task automatic load_missing_frames();
		longint p;
		if (voice_done)
			return;
		p = voice_pos >>> FRAC;
		if (p >= longint'(sample_len) - 1)
			return;
		for (longint f = p; f <= p + 1; f++) begin
			if (f < SAMPLE_DEPTH_DEF && !left_frames.exists(int'(f)))
				send_item(KIND_LOAD, f[15:0], rand_word(), rand_word());
		end
	endtask

	task automatic send_tick();
		load_missing_frames();
		send_item(KIND_TICK, rand_word(), rand_word(), rand_word());
		ticks_sent++;
	endtask

	// drop valid, wait for all pending results, let the sequencer drain
	task automatic settle_voice();
		in_valid <= 1'b0;
		while (pending_audio.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [19:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_SAMPLE_LENGTH: sample_len = val[16:0];
			REG_LOOP_MODE:     play_mode  = val[1:0];
			REG_LOOP_START:    loop_lo    = val[15:0];
			REG_LOOP_END:      loop_hi    = val[16:0];
			REG_STEP_RATE:     pos_step   = val;
			REG_STEREO:        stereo_on  = val[0];
			REG_GAIN:          level      = val[15:0];
			default: ;
		endcase
	endtask

	// random voice setup, loops mostly inside a short stretch near frame zero
	task automatic randomize_voice();
		logic [16:0] len, hi;
		logic [15:0] lo, lvl;
		logic [19:0] rate;
		logic [1:0]  mode;
		int          pick;
		pick = $urandom_range(99);
		if (pick < 8)
			len = 17'($urandom_range(1));
		else if (pick < 12)
			len = 17'd65536;
		else if (pick < 14)
			len = 17'h1FFFF;
		else if (pick < 18)
			len = 17'($urandom);
		else
			len = 17'($urandom_range(2, 48));
		if (len < 2) begin
			lo = '0;
			hi = len;
		end else begin
			lo = 16'($urandom_range(0, (len - 2 > 63) ? 63 : len - 2));
			hi = 17'(lo) + 17'($urandom_range(1, (len - lo > 64) ? 64 : len - lo));
		end
		if ($urandom_range(19) == 0)
			lo = 16'($urandom);
		if ($urandom_range(19) == 0)
			hi = 17'($urandom);
		pick = $urandom_range(99);
		if (pick < 5)
			rate = '0;
		else if (pick < 10)
			rate = 20'hFFFFF;
		else if (pick < 30)
			rate = 20'($urandom);
		else
			rate = 20'($urandom_range(20'h01000, 20'h30000));
		mode = ($urandom_range(9) == 0) ? LOOP_SPARE : 2'($urandom_range(2));
		pick = $urandom_range(99);
		if (pick < 10)
			lvl = '0;
		else if (pick < 20)
			lvl = 16'hFFFF;
		else if (pick < 30)
			lvl = GAIN_RST;
		else if (pick < 80)
			lvl = 16'($urandom_range(0, 32768));
		else
			lvl = 16'($urandom);
		write_reg(REG_SAMPLE_LENGTH, 20'(len));
		write_reg(REG_LOOP_MODE, 20'(mode));
		write_reg(REG_LOOP_START, 20'(lo));
		write_reg(REG_LOOP_END, 20'(hi));
		write_reg(REG_STEP_RATE, rate);
		write_reg(REG_STEREO, 20'($urandom_range(1)));
		write_reg(REG_GAIN, 20'(lvl));
	endtask

	// one playback run: setup, restart, ticks with some noise mixed in
	task automatic play_sequence();
		int ticks, pick;
		settle_voice();
		randomize_voice();
		if ($urandom_range(4) != 0)
			send_item(KIND_RESTART, rand_word(), rand_word(), rand_word());
		ticks = $urandom_range(4, 40);
		repeat (ticks) begin
			pick = $urandom_range(99);
			if (pick < 82) begin
				send_tick();
			end else if (pick < 90) begin
				send_item(KIND_LOAD, rand_word(), rand_word(), rand_word());
			end else if (pick < 94) begin
				send_item(KIND_RESTART, rand_word(), rand_word(), rand_word());
			end else if (pick < 97) begin
				send_item(KIND_SPARE, rand_word(), rand_word(), rand_word());
			end else begin
				// hold off until the block is empty, then carry on
				settle_voice();
				send_tick();
			end
		end
	endtask

	task automatic test_idle_voice();
		// finished out of reset: silence; unknown kind gives nothing
		send_tick();
		send_item(KIND_SPARE, 16'hFFFF, 16'h7FFF, 16'h8000);
		settle_voice();
		write_reg(REG_SPARE, 20'hFFFFF);
	endtask

	task automatic test_end_of_sample();
		send_item(KIND_LOAD, 16'd0, 16'h7FFF, 16'h8000);
		send_item(KIND_LOAD, 16'd1, 16'h8000, 16'h7FFF);
		send_item(KIND_LOAD, 16'd2, 16'hFFFF, 16'h0000);
		send_item(KIND_LOAD, 16'hFFFF, 16'h5A5A, 16'hA5A5);
		settle_voice();
		// rate and gain stay at their reset values here
		write_reg(REG_SAMPLE_LENGTH, 20'd3);
		write_reg(REG_STEREO, 20'd1);
		send_item(KIND_RESTART, 16'd0, 16'd0, 16'd0);
		// two playing ticks, the end of the sample, then a finished tick
		repeat (4) send_tick();
	endtask

	task automatic test_loop_modes();
		settle_voice();
		write_reg(REG_STEP_RATE, 20'h18000);
		write_reg(REG_GAIN, 20'h4000);
		write_reg(REG_LOOP_MODE, 20'(LOOP_PING));
		write_reg(REG_LOOP_START, 20'd0);
		write_reg(REG_LOOP_END, 20'd2);
		// second tick reflects at the loop end and turns backward
		send_item(KIND_RESTART, 16'd0, 16'd0, 16'd0);
		repeat (2) send_tick();
		// still backward with no loop: the position clamps at zero
		settle_voice();
		write_reg(REG_LOOP_MODE, 20'(LOOP_NONE));
		send_tick();
		// unused loop mode acts as no loop: step lands on the end, samples still out
		settle_voice();
		write_reg(REG_LOOP_MODE, 20'(LOOP_SPARE));
		write_reg(REG_STEP_RATE, 20'h30000);
		send_item(KIND_RESTART, 16'd0, 16'd0, 16'd0);
		send_tick();
		// forward loop wraps with the overshoot
		settle_voice();
		write_reg(REG_LOOP_MODE, 20'(LOOP_FWD));
		write_reg(REG_LOOP_START, 20'd1);
		write_reg(REG_STEP_RATE, 20'h18000);
		send_item(KIND_RESTART, 16'd0, 16'd0, 16'd0);
		repeat (2) send_tick();
	endtask

	task automatic test_frame_beyond_memory();
		// forward loop with start above end throws the position past memory
		settle_voice();
		write_reg(REG_SAMPLE_LENGTH, 20'h1FFFF);
		write_reg(REG_LOOP_START, 20'hFFFE);
		write_reg(REG_LOOP_END, 20'd1);
		write_reg(REG_STEP_RATE, 20'h10000);
		send_item(KIND_RESTART, 16'd0, 16'd0, 16'd0);
		repeat (3) send_tick();
	endtask

	task automatic test_random_playback(input int src_idle, input int snk_stall);
		int start;
		idle_pct  = src_idle;
		stall_pct = snk_stall;
		start     = items_sent;
		while (items_sent - start < RANDOM_ITEMS / 3)
			play_sequence();
	endtask

	initial begin
		arst_n     <= 1'b0;
		cfg_we     <= 1'b0;
		cfg_index  <= REG_SAMPLE_LENGTH;
		cfg_wdata  <= '0;
		in_valid   <= 1'b0;
		kind       <= KIND_LOAD;
		address    <= '0;
		left_word  <= '0;
		right_word <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_idle_voice();
		test_end_of_sample();
		test_loop_modes();
		test_frame_beyond_memory();
		test_random_playback(25, 83);
		test_random_playback(83, 25);
		test_random_playback(0, 0);

		// drain, bounded
		in_valid <= 1'b0;
		for (int i = 0; i < 20000 && pending_audio.size() != 0; i++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_audio.size() != 0) begin
			$error("%0d predicted results never came out", pending_audio.size());
			error_count++;
		end

		$display("%0d items sent, %0d of them ticks, %0d results compared",
			items_sent, ticks_sent, results_seen);
		$display("covered loop modes, mono and stereo, gain extremes, three idle profiles");
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// hard stop
	initial begin
		#10_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
